[rtl/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, muted while reset is held low.
`define SNH_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that is also checked during reset.
`define SNH_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

[rtl/snh_pkg.sv]
package snh_pkg;

    // Byte-level types
    typedef logic [7:0]        t_byte;
    typedef logic [3:0]        t_nibble;
    typedef logic [63:0]       t_word;
    typedef logic [15:0][7:0]  t_hash;

    // Multiplier on the uppercased byte, reduced mod 16
    localparam int HASH_MULT      = 29277;
    localparam int BYTE_COUNT     = 16;
    localparam t_nibble MULT_LOW  = 4'(HASH_MULT % BYTE_COUNT);

    // Offset subtracted from each uppercased byte
    localparam t_byte CHAR_OFFSET = 8'd32;

    // ASCII lowercase range and the case distance
    localparam t_byte LOWER_A     = 8'h61;
    localparam t_byte LOWER_Z     = 8'h7A;
    localparam t_byte CASE_DIFF   = 8'h20;

    // Configuration register indexes
    localparam int CFG_IDX_W      = 1;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_SEED_LOW  = 1'b0;
    localparam t_cfg_idx REG_SEED_HIGH = 1'b1;

endpackage

[rtl/snh_if.sv]
// Name byte channel
interface snh_name_if;
    logic           valid;
    logic           ready;
    snh_pkg::t_byte name_char;
    logic           end_of_name;

    modport source (output valid, name_char, end_of_name, input ready);
    modport sink   (input valid, name_char, end_of_name, output ready);
endinterface

// Hash result channel
interface snh_hash_if;
    logic           valid;
    logic           ready;
    snh_pkg::t_word hash_word;
    logic           word_last;

    modport source (output valid, hash_word, word_last, input ready);
    modport sink   (input valid, hash_word, word_last, output ready);
endinterface

// Configuration write channel
interface snh_cfg_if;
    logic              valid;
    logic              ready;
    snh_pkg::t_cfg_idx index;
    snh_pkg::t_word    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/snh_byte_upd.sv]
// Per-byte hash update: uppercase, pick a seed byte, accumulate.
module snh_byte_upd (
    input  snh_pkg::t_hash   i_seed,
    input  snh_pkg::t_byte   i_base,
    input  snh_pkg::t_byte   i_char,
    input  snh_pkg::t_nibble i_pos,
    input  snh_pkg::t_nibble i_blk,
    output snh_pkg::t_byte   o_byte
);

    snh_pkg::t_byte   up;
    snh_pkg::t_nibble tap;
    snh_pkg::t_nibble idx;
    snh_pkg::t_nibble prod;

    // Uppercase a..z only
    assign up = (i_char >= snh_pkg::LOWER_A && i_char <= snh_pkg::LOWER_Z) ?
                i_char - snh_pkg::CASE_DIFF : i_char;

    // First lookup position: (k + 2i) mod 16
    assign tap  = i_blk + {i_pos[2:0], 1'b0};

    // Only the low nibble of up*13 matters
    assign prod = 4'(up[3:0] * snh_pkg::MULT_LOW);
    assign idx  = prod + i_seed[tap][3:0] + tap;

    assign o_byte = i_base + up - snh_pkg::CHAR_OFFSET + i_seed[idx];

endmodule

[rtl/seeded_name_hash_unit.sv]
// Seeded name hash: one name byte accepted per cycle while no end word waits for
// output space. An end word passes the input register, then loads the output
// buffer, which offers the low hash word and, once that is taken, the high word.
// Throughput: 1 byte/cycle under that proviso; end words wait for buffer space.
// Reset: synchronous active low, seeds cleared, next byte starts a new name.
module seeded_name_hash_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    snh_name_if.sink  i_name,
    snh_cfg_if.sink   i_cfg,
    snh_hash_if.source o_hash
);

    // Seed registers
    snh_pkg::t_word   r_seed_low;
    snh_pkg::t_word   r_seed_high;
    snh_pkg::t_hash   seed;

    // Input register
    logic             r_in_vld;
    snh_pkg::t_byte   r_in_char;
    logic             r_in_end;

    // Hash state
    snh_pkg::t_hash   r_hash;
    snh_pkg::t_hash   n_hash;
    snh_pkg::t_nibble r_pos;
    snh_pkg::t_nibble r_blk;
    logic             r_fresh;

    // Output buffer: 2 = low word pending, 1 = high word pending
    logic [1:0]       r_out_cnt;
    snh_pkg::t_word   r_out_lo;
    snh_pkg::t_word   r_out_hi;

    snh_pkg::t_hash   src;
    snh_pkg::t_byte   base;
    snh_pkg::t_byte   upd;
    logic             out_pop;
    logic             out_space;
    logic             proc;

    assign seed = {r_seed_high, r_seed_low};

    // Config writes are always taken
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_low  <= '0;
            r_seed_high <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                snh_pkg::REG_SEED_LOW:  r_seed_low  <= i_cfg.data;
                snh_pkg::REG_SEED_HIGH: r_seed_high <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Handshake and stage advance
    assign out_pop   = (r_out_cnt != 2'd0) && o_hash.ready;
    assign out_space = (r_out_cnt == 2'd0) || (r_out_cnt == 2'd1 && o_hash.ready);
    assign proc      = r_in_vld && (!r_in_end || out_space);
    assign i_name.ready = !r_in_vld || proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_name.ready) begin
            r_in_vld <= i_name.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_name.valid && i_name.ready) begin
            r_in_char <= i_name.name_char;
            r_in_end  <= i_name.end_of_name;
        end
    end

    // Hash source: a fresh name starts from the seed
    assign src  = r_fresh ? seed : r_hash;
    assign base = src[r_pos];

    snh_byte_upd u_upd (
        .i_seed (seed),
        .i_base (base),
        .i_char (r_in_char),
        .i_pos  (r_pos),
        .i_blk  (r_blk),
        .o_byte (upd)
    );

    always_comb begin
        n_hash        = src;
        n_hash[r_pos] = upd;
    end

    // Hash state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_blk   <= '0;
            r_fresh <= 1'b1;
        end else if (proc) begin
            if (r_in_end) begin
                r_pos   <= '0;
                r_blk   <= '0;
                r_fresh <= 1'b1;
            end else begin
                r_pos   <= r_pos + 4'd1;
                r_fresh <= 1'b0;
                if (r_pos == 4'hF) begin
                    r_blk <= r_blk + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && !r_in_end) begin
            r_hash <= n_hash;
        end
    end

    // Output buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_cnt <= 2'd0;
        end else if (proc && r_in_end) begin
            r_out_cnt <= 2'd2;
        end else if (out_pop) begin
            r_out_cnt <= r_out_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && r_in_end) begin
            r_out_lo <= src[7:0];
            r_out_hi <= src[15:8];
        end
    end

    assign o_hash.valid     = (r_out_cnt != 2'd0);
    assign o_hash.word_last = (r_out_cnt == 2'd1);
    assign o_hash.hash_word = (r_out_cnt == 2'd2) ? r_out_lo : r_out_hi;

endmodule

[rtl/snh_checker.sv]
`include "assert_macros.svh"

// Port-level checks on the hash unit
module snh_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_in_end,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_last
);

    // Result word holds until taken
    `SNH_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid, "result word dropped while stalled")

    // Reset empties the output
    `SNH_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !i_out_valid, "result valid after reset")

    // First word of a hash is always followed by the last word
    `SNH_ASSERT(a_pair, i_clk, i_rst_n, i_out_valid && i_out_ready && !i_out_last |=> i_out_valid && i_out_last, "hash word pair broken")

    // A result appears only for an accepted end word
    `SNH_ASSERT(a_src, i_clk, i_rst_n, $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready && i_in_end, 2), "result without end word")

endmodule

bind seeded_name_hash_unit snh_checker u_snh_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_name.valid),
    .i_in_ready  (i_name.ready),
    .i_in_end    (i_name.end_of_name),
    .i_out_valid (o_hash.valid),
    .i_out_ready (o_hash.ready),
    .i_out_last  (o_hash.word_last)
);

[dv/seeded_name_hash_unit_test.sv]
`timescale 1ns / 100ps

module seeded_name_hash_unit_test;

    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_WORDS   = 280;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Sender idle and receiver stall odds, in percent
    int idle_pct  = 0;
    int stall_pct = 0;
    int name_words_sent = 0;

    snh_name_if name_ch();
    snh_cfg_if  cfg_ch();
    snh_hash_if hash_ch();

    seeded_name_hash_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_name  (name_ch),
        .i_cfg   (cfg_ch),
        .o_hash  (hash_ch)
    );

    typedef struct {
        snh_pkg::t_word word;
        logic           last;
    } t_hash_out;

    // Tracks seed and running hash, holds the hash words still owed by the block
    class name_hash_tracker;
        snh_pkg::t_hash   seed;
        snh_pkg::t_hash   hash_state;
        snh_pkg::t_nibble position;
        snh_pkg::t_nibble block;
        bit               fresh;
        t_hash_out        due_words[$];
        int               errors;

        function new();
            seed       = '0;
            hash_state = '0;
            position   = '0;
            block      = '0;
            fresh      = 1'b1;
            errors     = 0;
        endfunction

        task report(string msg);
            errors++;
            $display("%0t ERROR %s", $time, msg);
        endtask

        function int pending();
            return due_words.size();
        endfunction

        function void take_seed(snh_pkg::t_cfg_idx idx, snh_pkg::t_word data);
            case (idx)
                snh_pkg::REG_SEED_LOW:  seed[7:0]  = data;
                snh_pkg::REG_SEED_HIGH: seed[15:8] = data;
                default: ;
            endcase
        endfunction

        // Fold one name word into the running hash, or close the name
        function void take_name_word(snh_pkg::t_byte ch, logic eon);
            snh_pkg::t_byte   up;
            snh_pkg::t_nibble mix;
            snh_pkg::t_nibble pick;
            if (eon) begin
                if (fresh) hash_state = seed;
                due_words.push_back('{word: hash_state[7:0],  last: 1'b0});
                due_words.push_back('{word: hash_state[15:8], last: 1'b1});
                position = '0;
                block    = '0;
                fresh    = 1'b1;
                return;
            end
            if (fresh) begin
                hash_state = seed;
                fresh      = 1'b0;
            end
            up   = (ch >= snh_pkg::LOWER_A && ch <= snh_pkg::LOWER_Z) ?
                   snh_pkg::t_byte'(ch - snh_pkg::CASE_DIFF) : ch;
            mix  = snh_pkg::t_nibble'(block + snh_pkg::t_nibble'(position << 1));
            pick = snh_pkg::t_nibble'(up[3:0] * snh_pkg::MULT_LOW + seed[mix][3:0] + mix);
            hash_state[position] = snh_pkg::t_byte'(hash_state[position] + up
                                                    - snh_pkg::CHAR_OFFSET + seed[pick]);
            position = snh_pkg::t_nibble'(position + 1);
            if (position == '0) block = snh_pkg::t_nibble'(block + 1);
        endfunction

        task check_hash_word(snh_pkg::t_word word, logic last);
            t_hash_out due;
            if (due_words.size() == 0) begin
                report($sformatf("hash word %h last %0b with nothing owed", word, last));
                return;
            end
            due = due_words.pop_front();
            if (word !== due.word)
                report($sformatf("hash_word %h, predicted %h", word, due.word));
            if (last !== due.last)
                report($sformatf("word_last %0b, predicted %0b", last, due.last));
        endtask
    endclass

    name_hash_tracker tracker = new();

    // Clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Receiver back-pressure
    always @(posedge i_clk) begin
        hash_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Observe every handshake on all three channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready)
                tracker.take_seed(cfg_ch.index, cfg_ch.data);
            if (name_ch.valid && name_ch.ready)
                tracker.take_name_word(name_ch.name_char, name_ch.end_of_name);
            if (hash_ch.valid && hash_ch.ready)
                tracker.check_hash_word(hash_ch.hash_word, hash_ch.word_last);
        end
    end

    // Hang guard
    initial begin
        #2_000_000;
        $display("seeded_name_hash_unit_test NOT OK");
        $finish;
    end

    // Present one name word; valid stays high after acceptance
    task automatic send_name_word(snh_pkg::t_byte ch, logic eon);
        if ($urandom_range(99) < idle_pct) begin
            name_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        name_ch.valid       <= 1'b1;
        name_ch.name_char   <= ch;
        name_ch.end_of_name <= eon;
        do @(posedge i_clk); while (!name_ch.ready);
        name_words_sent++;
    endtask

    task automatic wait_for_hash();
        name_ch.valid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending() > 0);
    endtask

    // Drain and let the pipeline empty before touching the seed
    task automatic settle();
        wait_for_hash();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_seeds(snh_pkg::t_word low, snh_pkg::t_word high);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= snh_pkg::REG_SEED_LOW;
        cfg_ch.data  <= low;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.index <= snh_pkg::REG_SEED_HIGH;
        cfg_ch.data  <= high;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic snh_pkg::t_word rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // Mostly host-name like bytes, with a share of arbitrary ones
    function automatic snh_pkg::t_byte pick_char();
        case ($urandom_range(9))
            0, 1, 2, 3: return snh_pkg::t_byte'($urandom_range(8'h7A, 8'h61));
            4:          return snh_pkg::t_byte'($urandom_range(8'h5A, 8'h41));
            5:          return snh_pkg::t_byte'($urandom_range(8'h39, 8'h30));
            6:          return ($urandom_range(1) != 0) ? 8'h2E : 8'h2D;
            default:    return snh_pkg::t_byte'($urandom_range(255));
        endcase
    endfunction

    task automatic send_random_name();
        int len;
        int r;
        r = $urandom_range(99);
        if (r < 8)
            len = 0;
        else if (r < 95)
            len = $urandom_range(24, 1);
        else
            len = $urandom_range(300, 250);   // wraps the block count at 256 bytes or more
        repeat (len) send_name_word(pick_char(), 1'b0);
        send_name_word(snh_pkg::t_byte'($urandom_range(255)), 1'b1);
    endtask

    task automatic run_phase(int idle, int stall, snh_pkg::t_word low,
                             snh_pkg::t_word high);
        int start;
        bit paused;
        settle();
        idle_pct  = idle;
        stall_pct = stall;
        write_seeds(low, high);
        start  = name_words_sent;
        paused = 1'b0;
        while (name_words_sent - start < PHASE_WORDS) begin
            send_random_name();
            // once past half the phase, sender holds off until every owed word is back
            if (!paused && name_words_sent - start >= PHASE_WORDS / 2) begin
                wait_for_hash();
                paused = 1'b1;
            end
        end
    endtask

    snh_pkg::t_byte boundary_chars[10] = '{8'h61, 8'h7A, 8'h41, 8'h5A, 8'h60,
                                           8'h7B, 8'h00, 8'hFF, 8'h80, 8'h7F};

    initial begin
        name_ch.valid       = 1'b0;
        name_ch.name_char   = '0;
        name_ch.end_of_name = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = snh_pkg::REG_SEED_LOW;
        cfg_ch.data         = '0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty name straight after reset gives the cleared seed
        send_name_word(8'h00, 1'b1);
        settle();
        write_seeds(64'hFFFF_FFFF_FFFF_FFFF, 64'h0123_4567_89AB_CDEF);

        // Case boundaries, zero byte as data, high bytes; char ignored on end
        foreach (boundary_chars[n]) send_name_word(boundary_chars[n], 1'b0);
        send_name_word(8'hFF, 1'b1);
        send_name_word(8'h00, 1'b1);

        // Seed changes in the middle of a name
        repeat (3) send_name_word(pick_char(), 1'b0);
        settle();
        write_seeds(rand_word(), rand_word());
        repeat (3) send_name_word(pick_char(), 1'b0);
        send_name_word(8'h00, 1'b1);

        run_phase(0,  0,  rand_word(), rand_word());
        run_phase(45, 0,  64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        run_phase(0,  45, 64'h0, 64'h0);
        run_phase(36, 36, rand_word(), rand_word());

        wait_for_hash();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("seeded_name_hash_unit_test OK");
        end else begin
            $display("seeded_name_hash_unit_test NOT OK");
        end
        $finish;
    end

endmodule

[seeded_name_hash_unit.f]
+incdir+rtl
rtl/snh_pkg.sv
rtl/snh_if.sv
rtl/snh_byte_upd.sv
rtl/seeded_name_hash_unit.sv
rtl/snh_checker.sv
dv/seeded_name_hash_unit_test.sv
